// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL of the decimal power block.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define DPB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Expression must never be true outside reset.
`define DPB_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

// ----- hw/rtl/dpb_pkg.sv -----
// Package for the decimal power block: widths, constants, microcode types
// and the microcode program ROM. No dependencies.
package dpb_pkg;

    localparam int LIMBS            = 32;
    localparam int BASE_DIGIT_COUNT = 5;

    localparam int MANT_W      = 17;
    localparam int POINT_W     = 3;
    localparam int EXP_W       = 5;
    localparam int LIMB_W      = 14;
    localparam int INDEX_W     = 5;
    localparam int POINT_OUT_W = 7;
    localparam int SCALE_W     = POINT_W + EXP_W;
    localparam int POINT_MAX   = 127;

    localparam int ADDR_W  = $clog2(LIMBS);
    localparam int STRIP_W = $clog2(BASE_DIGIT_COUNT);
    localparam int CNT_W   = (ADDR_W > STRIP_W) ? ADDR_W : STRIP_W;

    localparam int DECIMAL    = 10;
    localparam int DIV10_W    = 20;
    localparam int DIV10_SH   = 23;
    localparam logic [DIV10_W-1:0] DIV10_MUL = 20'd838861;
    localparam int DIV10_PW   = MANT_W + DIV10_W;

    // acc = limb * mantissa + carry stays below 10000 * 2^17
    localparam int LIMB_BASE   = 10000;
    localparam int ACC_W       = 31;
    localparam int RECIP_W     = 31;
    localparam int RECIP_SH    = 44;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 31'd1759218605;
    localparam int PROD_W      = ACC_W + RECIP_W;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc S_IDLE      = 4'd0;
    localparam t_pc S_STRIP     = 4'd1;
    localparam t_pc S_FILL      = 4'd2;
    localparam t_pc S_PASS_CHK  = 4'd3;
    localparam t_pc S_RD        = 4'd4;
    localparam t_pc S_MUL       = 4'd5;
    localparam t_pc S_QUO       = 4'd6;
    localparam t_pc S_WB        = 4'd7;
    localparam t_pc S_PASS_END  = 4'd8;
    localparam t_pc S_OUT_RD    = 4'd9;
    localparam t_pc S_OUT_EMIT  = 4'd10;
    localparam t_pc S_DONE      = 4'd11;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_STRIP,
        OP_FILL,
        OP_PASS_START,
        OP_MUL,
        OP_QUO,
        OP_WB,
        OP_PASS_END,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_STRIP_MORE,
        C_LIMB_MORE,
        C_PASS_DONE
    } t_cond;

    // CNT_STEP: increment when the jump is taken, clear on fall-through
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLR,
        CNT_STEP
    } t_cnt;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_cnt  cnt;
        t_pc   target;
    } t_uword;

    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        unique case (pc)
            S_IDLE:     w = '{op: OP_LATCH,      cond: C_NO_START,   cnt: CNT_CLR,  target: S_IDLE};
            S_STRIP:    w = '{op: OP_STRIP,      cond: C_STRIP_MORE, cnt: CNT_STEP, target: S_STRIP};
            S_FILL:     w = '{op: OP_FILL,       cond: C_LIMB_MORE,  cnt: CNT_STEP, target: S_FILL};
            S_PASS_CHK: w = '{op: OP_PASS_START, cond: C_PASS_DONE,  cnt: CNT_HOLD, target: S_OUT_RD};
            S_RD:       w = '{op: OP_NOP,        cond: C_NEVER,      cnt: CNT_HOLD, target: S_IDLE};
            S_MUL:      w = '{op: OP_MUL,        cond: C_NEVER,      cnt: CNT_HOLD, target: S_IDLE};
            S_QUO:      w = '{op: OP_QUO,        cond: C_NEVER,      cnt: CNT_HOLD, target: S_IDLE};
            S_WB:       w = '{op: OP_WB,         cond: C_LIMB_MORE,  cnt: CNT_STEP, target: S_RD};
            S_PASS_END: w = '{op: OP_PASS_END,   cond: C_ALWAYS,     cnt: CNT_HOLD, target: S_PASS_CHK};
            S_OUT_RD:   w = '{op: OP_NOP,        cond: C_NEVER,      cnt: CNT_HOLD, target: S_IDLE};
            S_OUT_EMIT: w = '{op: OP_EMIT,       cond: C_LIMB_MORE,  cnt: CNT_STEP, target: S_OUT_RD};
            default:    w = '{op: OP_NOP,        cond: C_ALWAYS,     cnt: CNT_CLR,  target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/dpb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dpb_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/decimal_power_bignum.sv -----
// Top level of the decimal power block: microcoded sequencer and datapath.
// Depends on dpb_pkg, dpb_ram and assert_macros.svh.
//
// A transaction is taken when start is high and busy is low. The block strips
// trailing zero digits from the mantissa while fractional digits remain, then
// raises it to the exponent over LIMBS base-10000 limbs held in a RAM, and
// returns LIMBS results, least significant limb first, each on the output
// ports for one cycle under o_strobe. The results cannot be held off. The
// multiply-carry loop is a four-step microcode loop over the registered-read
// limb RAM (read, multiply, reciprocal divide by 10000, write back). busy
// stays high until the last result has been shown.
`include "assert_macros.svh"

module decimal_power_bignum (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [dpb_pkg::MANT_W-1:0]       i_base_digits,
    input  logic [dpb_pkg::POINT_W-1:0]      i_point_digits,
    input  logic [dpb_pkg::EXP_W-1:0]        i_exponent,
    output logic                             o_strobe,
    output logic [dpb_pkg::LIMB_W-1:0]       o_limb,
    output logic [dpb_pkg::INDEX_W-1:0]      o_limb_index,
    output logic                             o_last,
    output logic [dpb_pkg::POINT_OUT_W-1:0]  o_point_out,
    output logic                             o_overflow
);

    localparam int MANT_W      = dpb_pkg::MANT_W;
    localparam int POINT_W     = dpb_pkg::POINT_W;
    localparam int EXP_W       = dpb_pkg::EXP_W;
    localparam int LIMB_W      = dpb_pkg::LIMB_W;
    localparam int INDEX_W     = dpb_pkg::INDEX_W;
    localparam int POINT_OUT_W = dpb_pkg::POINT_OUT_W;
    localparam int SCALE_W     = dpb_pkg::SCALE_W;
    localparam int ADDR_W      = dpb_pkg::ADDR_W;
    localparam int CNT_W       = dpb_pkg::CNT_W;
    localparam int ACC_W       = dpb_pkg::ACC_W;
    localparam int PROD_W      = dpb_pkg::PROD_W;
    localparam int DIV10_PW    = dpb_pkg::DIV10_PW;

    // control
    dpb_pkg::t_pc    r_pc, n_pc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic            r_strobe, n_strobe;
    dpb_pkg::t_uword uw;
    logic            take;

    // datapath
    logic [MANT_W-1:0]      r_mant, n_mant;
    logic [POINT_W-1:0]     r_point, n_point;
    logic [EXP_W-1:0]       r_exp, n_exp;
    logic [EXP_W-1:0]       r_pass, n_pass;
    logic [MANT_W-1:0]      r_carry, n_carry;
    logic                   r_ovf, n_ovf;
    logic [ACC_W-1:0]       r_acc, n_acc;
    logic [PROD_W-1:0]      r_prod, n_prod;
    logic [POINT_OUT_W-1:0] r_point_out, n_point_out;
    logic [LIMB_W-1:0]      r_limb, n_limb;
    logic [INDEX_W-1:0]     r_limb_index, n_limb_index;
    logic                   r_last, n_last;
    logic [POINT_OUT_W-1:0] r_o_point, n_o_point;
    logic                   r_o_ovf, n_o_ovf;

    logic [DIV10_PW-1:0] div10_prod;
    logic [MANT_W-1:0]   q10;
    logic                rem10_zero;
    logic [MANT_W-1:0]   q_limb;
    logic [LIMB_W-1:0]   rem_limb;
    logic [SCALE_W-1:0]  scaled;
    logic [POINT_W-1:0]  point_clamped;

    logic              ram_we;
    logic [LIMB_W-1:0] ram_wdata;
    logic [LIMB_W-1:0] ram_rdata;

    dpb_ram #(
        .WIDTH (LIMB_W),
        .DEPTH (dpb_pkg::LIMBS)
    ) u_limb_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (r_cnt[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign uw   = dpb_pkg::ucode(r_pc);
    assign busy = (r_pc != dpb_pkg::S_IDLE);

    // mantissa / 10 by reciprocal, exact for 17-bit values
    assign div10_prod = DIV10_PW'(r_mant) * DIV10_PW'(dpb_pkg::DIV10_MUL);
    assign q10        = MANT_W'(div10_prod >> dpb_pkg::DIV10_SH);
    assign rem10_zero = (MANT_W'(q10 * MANT_W'(dpb_pkg::DECIMAL)) == r_mant);

    // acc / 10000 from the registered reciprocal product
    assign q_limb   = r_prod[dpb_pkg::RECIP_SH +: MANT_W];
    assign rem_limb = LIMB_W'(r_acc - ACC_W'(ACC_W'(q_limb) * ACC_W'(dpb_pkg::LIMB_BASE)));

    assign scaled        = SCALE_W'(r_point) * SCALE_W'(r_exp);
    assign point_clamped = (int'(i_point_digits) > dpb_pkg::BASE_DIGIT_COUNT)
                         ? POINT_W'(dpb_pkg::BASE_DIGIT_COUNT) : i_point_digits;

    always_comb begin
        unique case (uw.cond)
            dpb_pkg::C_NEVER:      take = 1'b0;
            dpb_pkg::C_ALWAYS:     take = 1'b1;
            dpb_pkg::C_NO_START:   take = !start;
            dpb_pkg::C_STRIP_MORE: take = (r_cnt != CNT_W'(dpb_pkg::BASE_DIGIT_COUNT - 1));
            dpb_pkg::C_LIMB_MORE:  take = (r_cnt != CNT_W'(dpb_pkg::LIMBS - 1));
            dpb_pkg::C_PASS_DONE:  take = (r_pass == r_exp);
            default:               take = 1'b0;
        endcase

        n_pc = take ? uw.target : dpb_pkg::t_pc'(r_pc + 1'b1);

        unique case (uw.cnt)
            dpb_pkg::CNT_HOLD: n_cnt = r_cnt;
            dpb_pkg::CNT_CLR:  n_cnt = '0;
            dpb_pkg::CNT_STEP: n_cnt = take ? CNT_W'(r_cnt + 1'b1) : '0;
            default:           n_cnt = '0;
        endcase
    end

    always_comb begin
        n_mant       = r_mant;
        n_point      = r_point;
        n_exp        = r_exp;
        n_pass       = r_pass;
        n_carry      = r_carry;
        n_ovf        = r_ovf;
        n_acc        = r_acc;
        n_prod       = r_prod;
        n_point_out  = r_point_out;
        n_limb       = r_limb;
        n_limb_index = r_limb_index;
        n_last       = r_last;
        n_o_point    = r_o_point;
        n_o_ovf      = r_o_ovf;
        n_strobe     = 1'b0;
        ram_we       = 1'b0;
        ram_wdata    = rem_limb;

        unique case (uw.op)
            dpb_pkg::OP_NOP: begin
            end
            dpb_pkg::OP_LATCH: begin
                if (start) begin
                    n_mant  = i_base_digits;
                    n_point = point_clamped;
                    n_exp   = i_exponent;
                end
            end
            dpb_pkg::OP_STRIP: begin
                if (r_point != '0 && rem10_zero) begin
                    n_mant  = q10;
                    n_point = POINT_W'(r_point - 1'b1);
                end
            end
            dpb_pkg::OP_FILL: begin
                ram_we      = 1'b1;
                ram_wdata   = (r_cnt == '0) ? LIMB_W'(1) : '0;
                n_ovf       = 1'b0;
                n_pass      = '0;
                n_point_out = (scaled > SCALE_W'(dpb_pkg::POINT_MAX))
                            ? POINT_OUT_W'(dpb_pkg::POINT_MAX) : POINT_OUT_W'(scaled);
            end
            dpb_pkg::OP_PASS_START: begin
                n_carry = '0;
            end
            dpb_pkg::OP_MUL: begin
                n_acc = ACC_W'(ram_rdata) * ACC_W'(r_mant) + ACC_W'(r_carry);
            end
            dpb_pkg::OP_QUO: begin
                n_prod = PROD_W'(r_acc) * PROD_W'(dpb_pkg::RECIP_MUL);
            end
            dpb_pkg::OP_WB: begin
                ram_we  = 1'b1;
                n_carry = q_limb;
            end
            dpb_pkg::OP_PASS_END: begin
                if (r_carry != '0) begin
                    n_ovf = 1'b1;
                end
                n_pass = EXP_W'(r_pass + 1'b1);
            end
            dpb_pkg::OP_EMIT: begin
                n_strobe     = 1'b1;
                n_limb       = ram_rdata;
                n_limb_index = INDEX_W'(r_cnt);
                n_last       = (r_cnt == CNT_W'(dpb_pkg::LIMBS - 1));
                n_o_point    = r_point_out;
                n_o_ovf      = r_ovf;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= dpb_pkg::S_IDLE;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_pc     <= n_pc;
            r_cnt    <= n_cnt;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mant       <= n_mant;
        r_point      <= n_point;
        r_exp        <= n_exp;
        r_pass       <= n_pass;
        r_carry      <= n_carry;
        r_ovf        <= n_ovf;
        r_acc        <= n_acc;
        r_prod       <= n_prod;
        r_point_out  <= n_point_out;
        r_limb       <= n_limb;
        r_limb_index <= n_limb_index;
        r_last       <= n_last;
        r_o_point    <= n_o_point;
        r_o_ovf      <= n_o_ovf;
    end

    assign o_strobe     = r_strobe;
    assign o_limb       = r_limb;
    assign o_limb_index = r_limb_index;
    assign o_last       = r_last & r_strobe;
    assign o_point_out  = r_o_point;
    assign o_overflow   = r_o_ovf;

    `DPB_ASSERT(a_start_sets_busy, i_clk, i_rst_n, start && !busy |=> busy, "busy not raised after start")
    `DPB_ASSERT_NEVER(a_no_result_idle, i_clk, i_rst_n, o_strobe && !busy, "result while idle")
    `DPB_ASSERT(a_last_index, i_clk, i_rst_n, o_last |-> (o_limb_index == INDEX_W'(dpb_pkg::LIMBS - 1)), "last on wrong limb")
    `DPB_ASSERT(a_index_steps, i_clk, i_rst_n, o_strobe && !o_last |-> ##2 (o_strobe && o_limb_index == INDEX_W'($past(o_limb_index, 2) + 1'b1)), "limb sequence broken")

endmodule

// ----- tb/decimal_power_bignum_tb.sv -----
// Testbench for decimal_power_bignum: drives mantissa/point/exponent
// transactions and checks every emitted limb against an in-bench predictor.
// Depends on dpb_pkg and the decimal_power_bignum RTL.
`timescale 1ns / 1ps

module decimal_power_bignum_tb;

    localparam int unsigned LIMB_RADIX  = dpb_pkg::LIMB_BASE;
    localparam int unsigned RADIX10     = dpb_pkg::DECIMAL;
    localparam int unsigned STRIP_MAX   = dpb_pkg::BASE_DIGIT_COUNT;
    localparam int unsigned SCALE_SAT   = dpb_pkg::POINT_MAX;
    localparam int unsigned NUM_LIMBS   = dpb_pkg::LIMBS;
    localparam int unsigned CARRY_MASK  = 32'h1FFFF;
    localparam int unsigned RANDOM_REQS = 90;
    localparam int unsigned SETTLE_CYC  = 64;
    localparam int unsigned LIMIT_CYC   = 2_000_000;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct {
        logic [dpb_pkg::MANT_W-1:0]  mant;
        logic [dpb_pkg::POINT_W-1:0] point;
        logic [dpb_pkg::EXP_W-1:0]   power;
        int unsigned                 idle_pct;
        bit                          drain;
    } power_req_t;

    typedef struct {
        logic [dpb_pkg::LIMB_W-1:0]      limb;
        logic [dpb_pkg::INDEX_W-1:0]     index;
        logic                            last;
        logic [dpb_pkg::POINT_OUT_W-1:0] point_out;
        logic                            overflow;
    } limb_res_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    logic [dpb_pkg::MANT_W-1:0]      i_base_digits  = '0;
    logic [dpb_pkg::POINT_W-1:0]     i_point_digits = '0;
    logic [dpb_pkg::EXP_W-1:0]       i_exponent     = '0;
    logic                            o_strobe;
    logic [dpb_pkg::LIMB_W-1:0]      o_limb;
    logic [dpb_pkg::INDEX_W-1:0]     o_limb_index;
    logic                            o_last;
    logic [dpb_pkg::POINT_OUT_W-1:0] o_point_out;
    logic                            o_overflow;

    power_req_t  pending_powers[$];
    limb_res_t   expected_limbs[$];
    power_req_t  active_req;
    int unsigned total_reqs     = 0;
    int unsigned accepted_reqs  = 0;
    int unsigned mismatches     = 0;
    int unsigned cycle_count    = 0;
    int unsigned phase_idle_pct = 0;

    decimal_power_bignum dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_base_digits  (i_base_digits),
        .i_point_digits (i_point_digits),
        .i_exponent     (i_exponent),
        .o_strobe       (o_strobe),
        .o_limb         (o_limb),
        .o_limb_index   (o_limb_index),
        .o_last         (o_last),
        .o_point_out    (o_point_out),
        .o_overflow     (o_overflow)
    );

    always #2 i_clk = ~i_clk;

    task automatic add_power(input int unsigned mant, input int unsigned point,
                             input int unsigned power, input bit drain);
        power_req_t r;
        r.mant     = mant[dpb_pkg::MANT_W-1:0];
        r.point    = point[dpb_pkg::POINT_W-1:0];
        r.power    = power[dpb_pkg::EXP_W-1:0];
        r.idle_pct = phase_idle_pct;
        r.drain    = drain;
        pending_powers.push_back(r);
        total_reqs++;
    endtask

    // Strip trailing zeros, raise to the power limb by limb, queue all limbs.
    task automatic push_power_limbs(input power_req_t r);
        int unsigned     store[NUM_LIMBS];
        int unsigned     mant;
        int unsigned     point;
        int unsigned     carry;
        int unsigned     scaled;
        longint unsigned acc;
        bit              ovf;
        limb_res_t       res;
        mant  = 32'(r.mant);
        point = 32'(r.point);
        if (point > STRIP_MAX) begin
            point = STRIP_MAX;
        end
        for (int i = 0; i < STRIP_MAX; i++) begin
            if (point != 0 && mant % RADIX10 == 0) begin
                mant  = mant / RADIX10;
                point = point - 1;
            end
        end
        foreach (store[k]) begin
            store[k] = 0;
        end
        store[0] = 1;
        ovf      = 1'b0;
        for (int p = 0; p < int'(r.power); p++) begin
            carry = 0;
            for (int k = 0; k < NUM_LIMBS; k++) begin
                acc      = 64'(store[k]);
                acc      = acc * 64'(mant) + 64'(carry);
                store[k] = 32'(acc % 64'(LIMB_RADIX));
                carry    = 32'(acc / 64'(LIMB_RADIX)) & CARRY_MASK;
            end
            if (carry != 0) begin
                ovf = 1'b1;
            end
        end
        scaled = point * 32'(r.power);
        if (scaled > SCALE_SAT) begin
            scaled = SCALE_SAT;
        end
        for (int k = 0; k < NUM_LIMBS; k++) begin
            res.limb      = store[k][dpb_pkg::LIMB_W-1:0];
            res.index     = k[dpb_pkg::INDEX_W-1:0];
            res.last      = (k == NUM_LIMBS - 1);
            res.point_out = scaled[dpb_pkg::POINT_OUT_W-1:0];
            res.overflow  = ovf;
            expected_limbs.push_back(res);
        end
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // Driver: holds start until the transaction is taken, idles at random between.
    always @(posedge i_clk) begin : driver
        power_req_t nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (start) begin
                push_power_limbs(active_req);
                accepted_reqs++;
            end
            if (pending_powers.size() > 0
                && !(pending_powers[0].drain && (expected_limbs.size() > 0 || busy))
                && $urandom_range(99) >= pending_powers[0].idle_pct) begin
                nxt            = pending_powers.pop_front();
                active_req     = nxt;
                i_base_digits  <= nxt.mant;
                i_point_digits <= nxt.point;
                i_exponent     <= nxt.power;
                start          <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        limb_res_t want;
        if (i_rst_n && o_strobe) begin
            if (expected_limbs.size() == 0) begin
                note_mismatch($sformatf("unexpected limb %0d idx=%0d last=%0b pt=%0d ovf=%0b",
                    o_limb, o_limb_index, o_last, o_point_out, o_overflow));
            end else begin
                want = expected_limbs.pop_front();
                if (o_limb !== want.limb || o_limb_index !== want.index
                    || o_last !== want.last || o_point_out !== want.point_out
                    || o_overflow !== want.overflow) begin
                    note_mismatch($sformatf(
                        "exp limb=%0d idx=%0d last=%0b pt=%0d ovf=%0b, got limb=%0d idx=%0d last=%0b pt=%0d ovf=%0b",
                        want.limb, want.index, want.last, want.point_out, want.overflow,
                        o_limb, o_limb_index, o_last, o_point_out, o_overflow));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYC) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned mant;
        int unsigned power;

        phase_idle_pct = 6;
        add_power(0, 0, 0, 1'b0);
        add_power(99999, 5, 0, 1'b0);
        add_power(131071, 7, 31, 1'b0);
        add_power(99999, 5, 25, 1'b0);
        add_power(99999, 0, 25, 1'b0);
        add_power(0, 5, 3, 1'b0);
        add_power(0, 0, 5, 1'b0);
        add_power(1, 0, 25, 1'b0);
        add_power(12000, 5, 3, 1'b0);
        add_power(10000, 2, 4, 1'b1);
        add_power(100000, 5, 1, 1'b0);
        add_power(12345, 3, 25, 1'b0);
        add_power(50, 5, 25, 1'b0);
        add_power(99999, 5, 31, 1'b0);
        add_power(2, 0, 31, 1'b0);
        add_power(9999, 4, 1, 1'b0);
        add_power(10000, 0, 1, 1'b0);
        add_power(32'h15555, 6, 21, 1'b0);
        add_power(32'h0AAAA, 1, 10, 1'b0);
        add_power(65536, 3, 16, 1'b0);
        add_power(120, 1, 26, 1'b0);

        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n == RANDOM_REQS / 3) begin
                phase_idle_pct = 46;
            end else if (n == 2 * RANDOM_REQS / 3) begin
                phase_idle_pct = 0;
            end
            case ($urandom_range(3))
                0: mant = $urandom_range(131071);
                1: mant = $urandom_range(99999);
                2: mant = $urandom_range(99) * (10 ** $urandom_range(1, 3));
                default: mant = $urandom_range(20);
            endcase
            power = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(25);
            add_power(mant, $urandom_range(7), power,
                      n == RANDOM_REQS / 3 || n == 2 * RANDOM_REQS / 3);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_reqs < total_reqs || expected_limbs.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
